### design/wag_pkg.sv
`timescale 1ns / 1ps

package wag_pkg;

  localparam int MASK_W   = 8;
  localparam int CHOSEN_W = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_COMMIT
  } wag_state_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic nonempty;
    logic winner;
    logic take;
  } lane_ctl_t;

endpackage

### design/weighted_age_arbiter_core.sv
`timescale 1ns / 1ps
// Channel  Handshake          Word
// in       in_valid/in_stall  in_nonempty_mask[7:0], in_supply_mask[7:0]
// out      out_valid/out_stall out_chosen_input[2:0], out_packet_taken
//
// One word in flight at a time: each word passes the registered compare tree of
// depth LVLS = clog2(NUM_INPUTS) between the lane activity update and the age
// commit of the same word.
// Synchronous active-low reset clears all lanes: ages zero, all inputs inactive.
// A word held in the output register does not block the next input word; the
// commit of that next word waits only while out_stall holds the previous one.

module weighted_age_arbiter_core #(
  parameter int NUM_INPUTS = 8,
  parameter int AGE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wag_pkg::MASK_W-1:0]    in_nonempty_mask,
  input  logic [wag_pkg::MASK_W-1:0]    in_supply_mask,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wag_pkg::CHOSEN_W-1:0]  out_chosen_input,
  output logic                          out_packet_taken
);
  import wag_pkg::*;

  localparam int LVLS   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int IDX_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int CNT_W  = (LVLS > 1) ? $clog2(LVLS) : 1;

  wag_state_t state_r;
  wag_state_t state_nxt;

  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [MASK_W-1:0]   supply_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [CHOSEN_W-1:0] out_chosen_r;
  logic                out_taken_r;

  logic                accept;
  logic                commit;
  logic                lane_load;
  logic                lane_commit;
  logic                merge_done;
  logic                slot_free;

  logic [NUM_INPUTS-1:0] lane_act;
  logic [AGE_BITS-1:0]   lane_key [NUM_INPUTS];
  logic [NUM_INPUTS-1:0] win_vec;
  logic [NUM_INPUTS-1:0] sup_vec;
  logic                  root_vld;
  logic [IDX_W-1:0]      root_idx;
  logic [IDX_W-1:0]      win_idx;
  logic [CHOSEN_W+IDX_W-1:0] chosen_ext;
  logic                  taken;

  assign accept     = in_valid && !in_stall;
  assign slot_free  = !out_valid_r || !out_stall;
  assign merge_done = (cnt_r == CNT_W'(LVLS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MERGE;
      end
      S_MERGE: begin
        if (merge_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    lane_commit = 1'b0;
    cnt_nxt     = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_MERGE: begin
        cnt_nxt = merge_done ? '0 : cnt_r + CNT_W'(1);
      end
      S_COMMIT: begin
        lane_commit = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign lane_load = accept;
  assign commit    = lane_commit;

  for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
    logic      ne;
    lane_ctl_t ctl;

    if (i < MASK_W) begin : g_bit
      assign ne         = in_nonempty_mask[i];
      assign sup_vec[i] = supply_r[i];
    end else begin : g_none
      assign ne         = 1'b0;
      assign sup_vec[i] = 1'b0;
    end

    assign win_vec[i]   = (win_idx == IDX_W'(i));
    assign ctl.load     = lane_load;
    assign ctl.commit   = lane_commit;
    assign ctl.nonempty = ne;
    assign ctl.winner   = win_vec[i];
    assign ctl.take     = sup_vec[i];

    wag_lane #(
      .AGE_BITS (AGE_BITS),
      .LANE_IDX (i)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .active (lane_act[i]),
      .key    (lane_key[i])
    );
  end

  wag_merge #(
    .NUM_INPUTS (NUM_INPUTS),
    .AGE_BITS   (AGE_BITS),
    .IDX_W      (IDX_W),
    .LVLS       (LVLS)
  ) u_merge (
    .clk      (clk),
    .leaf_vld (lane_act),
    .leaf_key (lane_key),
    .root_vld (root_vld),
    .root_idx (root_idx)
  );

  assign win_idx    = root_vld ? root_idx : '0;
  assign taken      = |(win_vec & sup_vec);
  assign chosen_ext = {CHOSEN_W'(0), win_idx};

  assign out_valid_nxt = commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      supply_r <= in_supply_mask;
    end
    if (commit) begin
      out_chosen_r <= chosen_ext[CHOSEN_W-1:0];
      out_taken_r  <= taken;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_input = out_chosen_r;
  assign out_packet_taken = out_taken_r;

  a_commit_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed word not presented");

  a_accept_merges: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MERGE))
    else $error("accepted word did not enter merge");

  a_winner_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) && root_vld |-> ((lane_act & win_vec) != '0))
    else $error("granted lane is not active");

  a_none_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) && !root_vld |-> (lane_act == '0))
    else $error("active lane missed by merge");

endmodule

### design/wag_lane.sv
`timescale 1ns / 1ps

module wag_lane #(
  parameter int AGE_BITS = 16,
  parameter int LANE_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wag_pkg::lane_ctl_t    ctl,
  output logic                  active,
  output logic [AGE_BITS-1:0]   key
);
  import wag_pkg::*;

  logic                active_r;
  logic                active_nxt;
  logic [AGE_BITS-1:0] age_r;
  logic [AGE_BITS-1:0] age_nxt;

  always_comb begin
    active_nxt = active_r;
    age_nxt    = age_r;
    if (ctl.load) begin
      active_nxt = ctl.nonempty;
      if (ctl.nonempty && !active_r) begin
        age_nxt = '0;
      end
    end else if (ctl.commit) begin
      if (ctl.winner) begin
        if (ctl.take) begin
          age_nxt = '0;
        end
      end else if (active_r && (age_r != '1)) begin
        age_nxt = age_r + AGE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      age_r    <= '0;
    end else begin
      active_r <= active_nxt;
      age_r    <= age_nxt;
    end
  end

  assign active = active_r;
  assign key    = active_r ? (age_r >> LANE_IDX) : '0;

endmodule

### design/wag_merge.sv
`timescale 1ns / 1ps

module wag_merge #(
  parameter int NUM_INPUTS = 8,
  parameter int AGE_BITS   = 16,
  parameter int IDX_W      = 3,
  parameter int LVLS       = 3
) (
  input  logic                  clk,
  input  logic [NUM_INPUTS-1:0] leaf_vld,
  input  logic [AGE_BITS-1:0]   leaf_key [NUM_INPUTS],
  output logic                  root_vld,
  output logic [IDX_W-1:0]      root_idx
);
  import wag_pkg::*;

  localparam int LEAVES = 1 << LVLS;

  logic                node_vld_r [LEAVES-1];
  logic [AGE_BITS-1:0] node_key_r [LEAVES-1];
  logic [IDX_W-1:0]    node_idx_r [LEAVES-1];

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic                l_vld;
    logic [AGE_BITS-1:0] l_key;
    logic [IDX_W-1:0]    l_idx;
    logic                r_vld;
    logic [AGE_BITS-1:0] r_key;
    logic [IDX_W-1:0]    r_idx;
    logic                pick_r;

    if (2 * k >= LEAVES) begin : g_leaf
      localparam int LI = 2 * k - LEAVES;
      localparam int RI = 2 * k + 1 - LEAVES;
      if (LI < NUM_INPUTS) begin : g_l
        assign l_vld = leaf_vld[LI];
        assign l_key = leaf_key[LI];
      end else begin : g_lpad
        assign l_vld = 1'b0;
        assign l_key = '0;
      end
      if (RI < NUM_INPUTS) begin : g_r
        assign r_vld = leaf_vld[RI];
        assign r_key = leaf_key[RI];
      end else begin : g_rpad
        assign r_vld = 1'b0;
        assign r_key = '0;
      end
      assign l_idx = IDX_W'(LI);
      assign r_idx = IDX_W'(RI);
    end else begin : g_inner
      assign l_vld = node_vld_r[2 * k - 1];
      assign l_key = node_key_r[2 * k - 1];
      assign l_idx = node_idx_r[2 * k - 1];
      assign r_vld = node_vld_r[2 * k];
      assign r_key = node_key_r[2 * k];
      assign r_idx = node_idx_r[2 * k];
    end

    assign pick_r = r_vld && (!l_vld || (r_key > l_key));

    always_ff @(posedge clk) begin
      node_vld_r[k-1] <= pick_r ? r_vld : l_vld;
      node_key_r[k-1] <= pick_r ? r_key : l_key;
      node_idx_r[k-1] <= pick_r ? r_idx : l_idx;
    end
  end

  assign root_vld = node_vld_r[0];
  assign root_idx = node_idx_r[0];

endmodule

### test/weighted_age_arbiter_core_tb.sv
`timescale 1ns / 1ps

module weighted_age_arbiter_core_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 800;

  typedef struct packed {
    logic [wag_pkg::CHOSEN_W-1:0] chosen;
    logic                         taken;
  } grant_t;

  class arbiter_scoreboard;
    localparam int LANES = 8;
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    logic [15:0] lane_age [LANES];
    logic [LANES-1:0] lane_active;
    grant_t grants [$];
    int errors;
    int checked;
    int taken_seen;

    function new();
      for (int i = 0; i < LANES; i++) lane_age[i] = '0;
      lane_active = '0;
      errors = 0;
      checked = 0;
      taken_seen = 0;
    endfunction

    function int pending();
      return grants.size();
    endfunction

    function void note_input(logic [7:0] nonempty, logic [7:0] supply);
      int win;
      bit have;
      logic [15:0] best;
      logic [15:0] weighted;
      grant_t g;
      win = 0;
      have = 0;
      best = '0;
      for (int i = 0; i < LANES; i++) begin
        if (nonempty[i]) begin
          if (!lane_active[i]) begin
            lane_active[i] = 1'b1;
            lane_age[i] = '0;
          end
        end else begin
          lane_active[i] = 1'b0;
        end
      end
      for (int i = 0; i < LANES; i++) begin
        if (lane_active[i]) begin
          weighted = lane_age[i] >> i;
          if (!have || weighted > best) begin
            have = 1;
            best = weighted;
            win = i;
          end
        end
      end
      for (int i = 0; i < LANES; i++) begin
        if (i != win && lane_active[i] && lane_age[i] != AGE_MAX) lane_age[i]++;
      end
      if (supply[win]) lane_age[win] = '0;
      g.chosen = win[wag_pkg::CHOSEN_W-1:0];
      g.taken = supply[win];
      grants.push_back(g);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [wag_pkg::CHOSEN_W-1:0] chosen, logic taken);
      grant_t want;
      if (grants.size() == 0) begin
        report($sformatf("grant to input %0d with nothing outstanding", chosen));
        return;
      end
      want = grants.pop_front();
      if (chosen !== want.chosen)
        report($sformatf("grant %0d: input %0d, wanted %0d", checked, chosen, want.chosen));
      if (taken !== want.taken)
        report($sformatf("grant %0d: packet_taken %b, wanted %b", checked, taken, want.taken));
      if (want.taken) taken_seen++;
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [wag_pkg::MASK_W-1:0] in_nonempty_mask = '0;
  logic [wag_pkg::MASK_W-1:0] in_supply_mask = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [wag_pkg::CHOSEN_W-1:0] out_chosen_input;
  logic out_packet_taken;

  arbiter_scoreboard sb = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int words_sent = 0;
  int directed_words = 0;
  int rx_wait = 0;
  int idle_cycles = 0;
  int win_seen [8];

  weighted_age_arbiter_core #(
    .NUM_INPUTS(8),
    .AGE_BITS(16)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_nonempty_mask(in_nonempty_mask),
    .in_supply_mask(in_supply_mask),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_chosen_input(out_chosen_input),
    .out_packet_taken(out_packet_taken)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_chosen_input, out_packet_taken);
        win_seen[out_chosen_input]++;
        if (sb.checked % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 16);
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles, %0d grants outstanding",
                 $realtime, idle_cycles, sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] nonempty, input logic [7:0] supply);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_nonempty_mask <= nonempty;
    in_supply_mask <= supply;
    do @(posedge clk); while (in_stall);
    sb.note_input(nonempty, supply);
    words_sent++;
  endtask

  // hold off the sender until every outstanding grant is back
  task automatic drain_grants();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    logic [7:0] held_mask;
    logic [7:0] nonempty;
    logic [7:0] supply;
    int pick;
    for (int i = 0; i < 8; i++) win_seen[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(8'h00, 8'h00);
    send_word(8'h00, 8'hFF);
    send_word(8'hFF, 8'h00);
    send_word(8'hFF, 8'h00);
    send_word(8'hFF, 8'h00);
    send_word(8'hFF, 8'hFE);
    send_word(8'hFF, 8'hFF);
    send_word(8'hFF, 8'hFF);
    send_word(8'h0F, 8'h00);
    send_word(8'h00, 8'h00);
    send_word(8'h0F, 8'h00);
    send_word(8'h81, 8'h00);
    send_word(8'h81, 8'h80);
    for (int i = 0; i < 8; i++)
      send_word(8'(1 << i), (i % 2 == 1) ? 8'(1 << i) : ~8'(1 << i));
    send_word(8'hAA, 8'h55);
    send_word(8'h55, 8'hAA);
    directed_words = words_sent;
    drain_grants();

    held_mask = 8'($urandom);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) drain_grants();
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
        nonempty = 8'($urandom);
        supply = 8'($urandom);
      end else begin
        if (pick < 6) held_mask[$urandom_range(0, 7)] ^= 1'b1;
        nonempty = held_mask;
        supply = (pick < 14) ? 8'($urandom & $urandom)
                             : 8'($urandom & $urandom & $urandom);
      end
      send_word(nonempty, supply);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d request words (%0d directed), %0d grants checked, %0d taking a packet",
             words_sent, directed_words, sb.checked, sb.taken_seen);
    $display("grants per input 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             win_seen[0], win_seen[1], win_seen[2], win_seen[3],
             win_seen[4], win_seen[5], win_seen[6], win_seen[7]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
